@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/crp_pkg.sv @@
// Shared constants, types and the CORDIC angle table.
package crp_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 20;
  localparam int BEARING_W     = FRAC_BITS + 3;
  localparam int RATE_W        = 33;
  localparam int CORDIC_W      = 36;
  localparam int ANG_SH        = 61 - FRAC_BITS;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;

  localparam int FRONT_LAT  = 3;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int CORDIC_LAT = CORDIC_STAGES + 3;
  localparam int BEAR_DELAY = FRONT_LAT + SQRT_LAT + DIV_LAT - CORDIC_LAT;
  localparam int TOTAL_LAT  = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;

  typedef struct packed {
    logic [63:0] dmag;
    logic        dneg;
  } dot_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] s;
    dot_t        dot;
  } root_t;

  // atan(2^-i), binary angle, full turn = 2^32
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051D;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2E;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000028;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000002;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/crp_front.sv @@
// Front end: magnitudes, squares, dot product terms and their sums.
module crp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  output logic                 out_valid,
  output logic [63:0]          sum_sq,
  output crp_pkg::dot_t        dot
);
  import crp_pkg::*;

  logic        v1, v2;
  logic [31:0] ax, ay, mvx, mvy;
  logic        s1a, s2a, s1b, s2b;
  logic [63:0] sqx, sqy, p1, p2;
  dot_t        dot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    if (s1b == s2b) begin
      dot_next.dmag = p1 + p2;
      dot_next.dneg = s1b;
    end else if (p1 >= p2) begin
      dot_next.dmag = p1 - p2;
      dot_next.dneg = s1b;
    end else begin
      dot_next.dmag = p2 - p1;
      dot_next.dneg = s2b;
    end
  end

  always_ff @(posedge clk) begin
    ax  <= pos_x[31] ? 32'(-pos_x) : 32'(pos_x);
    ay  <= pos_y[31] ? 32'(-pos_y) : 32'(pos_y);
    mvx <= vel_x[31] ? 32'(-vel_x) : 32'(vel_x);
    mvy <= vel_y[31] ? 32'(-vel_y) : 32'(vel_y);
    s1a <= pos_x[31] ^ vel_x[31];
    s2a <= pos_y[31] ^ vel_y[31];
    sqx <= 64'(ax) * 64'(ax);
    sqy <= 64'(ay) * 64'(ay);
    p1  <= 64'(ax) * 64'(mvx);
    p2  <= 64'(ay) * 64'(mvy);
    s1b <= s1a;
    s2b <= s2a;
    sum_sq <= sqx + sqy;
    dot <= dot_next;
  end

endmodule

@@ hdl/crp_sqrt.sv @@
// Pipelined bitwise integer square root with round-to-nearest stage.
module crp_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   sum_sq,
  input  crp_pkg::dot_t dot_in,
  output crp_pkg::root_t root
);
  import crp_pkg::*;

  logic [63:0] rn [0:SQRT_STEPS];
  logic [63:0] rr [0:SQRT_STEPS];
  logic        vv [0:SQRT_STEPS];
  dot_t        sd [0:SQRT_STEPS];

  assign rn[0] = sum_sq;
  assign rr[0] = '0;
  assign vv[0] = in_valid;
  assign sd[0] = dot_in;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [64:0] trial;
    assign trial = {1'b0, rr[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else begin
        vv[k+1] <= vv[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
      if ({1'b0, rn[k]} >= trial) begin
        rn[k+1] <= rn[k] - trial[63:0];
        rr[k+1] <= (rr[k] >> 1) + BIT;
      end else begin
        rn[k+1] <= rn[k];
        rr[k+1] <= rr[k] >> 1;
      end
    end
  end

  // round: bump when remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rst) begin
      root.valid <= 1'b0;
    end else begin
      root.valid <= vv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    root.s   <= rr[SQRT_STEPS][31:0]
              + 32'(rn[SQRT_STEPS] > {32'b0, rr[SQRT_STEPS][31:0]});
    root.dot <= sd[SQRT_STEPS];
  end

endmodule

@@ hdl/crp_div.sv @@
// Pipelined restoring divider: dot magnitude over range, rounded, saturated.
module crp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  crp_pkg::root_t              root,
  output logic                        out_valid,
  output logic [31:0]                 range,
  output logic [crp_pkg::RATE_W-1:0]  rate
);
  import crp_pkg::*;

  logic [63:0]          dr  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dq  [0:DIV_STEPS];
  logic [31:0]          ds  [0:DIV_STEPS];
  logic                 dovf[0:DIV_STEPS];
  logic                 dng [0:DIV_STEPS];
  logic                 dv  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= root.valid;
    end
  end

  // quotient of 2^33 or more saturates anyway
  always_ff @(posedge clk) begin
    dr[0]   <= root.dot.dmag;
    dq[0]   <= '0;
    ds[0]   <= root.s;
    dovf[0] <= {1'b0, root.dot.dmag[63:33]} >= root.s;
    dng[0]  <= root.dot.dneg;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [64:0] dsh;
    assign dsh = {33'b0, ds[j]} << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      ds[j+1]   <= ds[j];
      dovf[j+1] <= dovf[j];
      dng[j+1]  <= dng[j];
      if ({1'b0, dr[j]} >= dsh) begin
        dr[j+1] <= dr[j] - dsh[63:0];
        dq[j+1] <= {dq[j][DIV_STEPS-2:0], 1'b1};
      end else begin
        dr[j+1] <= dr[j];
        dq[j+1] <= {dq[j][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  logic [DIV_STEPS:0] qr;
  logic [RATE_W-1:0]  mag;
  logic [31:0]        s_f;
  logic [RATE_W-1:0]  rate_next;

  always_comb begin
    s_f = ds[DIV_STEPS];
    qr  = {1'b0, dq[DIV_STEPS]}
        + (DIV_STEPS + 1)'({dr[DIV_STEPS][31:0], 1'b0} >= {1'b0, s_f});
    if (dng[DIV_STEPS]) begin
      if (dovf[DIV_STEPS] || qr > (DIV_STEPS + 1)'(34'h1_0000_0000)) begin
        mag = RATE_W'(34'h1_0000_0000);
      end else begin
        mag = qr[RATE_W-1:0];
      end
      rate_next = RATE_W'(-mag);
    end else begin
      if (dovf[DIV_STEPS] || qr > (DIV_STEPS + 1)'(34'h0_FFFF_FFFF)) begin
        mag = RATE_W'(34'h0_FFFF_FFFF);
      end else begin
        mag = qr[RATE_W-1:0];
      end
      rate_next = mag;
    end
    if (s_f == '0) begin
      rate_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    range <= s_f;
    rate  <= rate_next;
  end

endmodule

@@ hdl/crp_cordic.sv @@
// Pipelined CORDIC vectoring atan2 with scaling to radians.
module crp_cordic (
  input  logic                               clk,
  input  logic signed [31:0]                 pos_x,
  input  logic signed [31:0]                 pos_y,
  output logic signed [crp_pkg::BEARING_W-1:0] bearing
);
  import crp_pkg::*;

  logic signed [CORDIC_W-1:0] cx [0:CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] cy [0:CORDIC_STAGES];
  logic        [31:0]         cz [0:CORDIC_STAGES];

  logic signed [CORDIC_W-1:0] xe, ye;
  assign xe = CORDIC_W'(pos_x);
  assign ye = CORDIC_W'(pos_y);

  // quadrant pre-rotation for the left half plane
  always_ff @(posedge clk) begin
    if (xe < 0) begin
      if (ye >= 0) begin
        cx[0] <= ye;
        cy[0] <= -xe;
        cz[0] <= 32'h40000000;
      end else begin
        cx[0] <= -ye;
        cy[0] <= xe;
        cz[0] <= 32'hC0000000;
      end
    end else begin
      cx[0] <= xe;
      cy[0] <= ye;
      cz[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [31:0] ANG = atan_entry(5'(i));
    logic signed [CORDIC_W-1:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (cy[i] >= 0) begin
        cx[i+1] <= cx[i] + dx;
        cy[i+1] <= cy[i] - dy;
        cz[i+1] <= cz[i] + ANG;
      end else begin
        cx[i+1] <= cx[i] - dx;
        cy[i+1] <= cy[i] + dy;
        cz[i+1] <= cz[i] - ANG;
      end
    end
  end

  logic [63:0] prod;
  logic        neg;
  logic [64:0] rnd;
  logic [31:0] zf;

  assign zf  = cz[CORDIC_STAGES];
  assign rnd = ({1'b0, prod} + (65'(1) << (ANG_SH - 1))) >> ANG_SH;

  always_ff @(posedge clk) begin
    neg  <= zf[31];
    prod <= 64'(zf[31] ? 32'(-zf) : zf) * 64'(TWO_PI_Q29);
    bearing <= neg ? BEARING_W'(-rnd[BEARING_W-1:0]) : rnd[BEARING_W-1:0];
  end

endmodule

@@ hdl/cartesian_to_polar_radar_top.sv @@
// Top level: radar measurement function, Cartesian track state to polar.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  command   | start / busy     | pos_x, pos_y, vel_x, vel_y (Q16.16)
//  result    | done (1 cycle)   | range (Q16.16), bearing (Q3.16),
//            |                  | range_rate (Q17.16)
//
// One command transfer per cycle; busy is always low. The result of a
// transfer passes through 3 front-end stages (abs, 32x32 products,
// sums), 33 for the one-bit-per-stage square root plus rounding, 35 for
// the overflow check, 33 quotient-bit stages and saturation, and one
// output register. The bearing CORDIC runs alongside and is delayed to
// line up. Reset (synchronous) clears the valid bits only. The receiver
// cannot stall, so nothing in the pipe ever holds.
module cartesian_to_polar_radar_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [31:0]                 pos_x,
  input  logic signed [31:0]                 pos_y,
  input  logic signed [31:0]                 vel_x,
  input  logic signed [31:0]                 vel_y,
  output logic                               done,
  output logic [31:0]                        range,
  output logic signed [crp_pkg::BEARING_W-1:0] bearing,
  output logic signed [crp_pkg::RATE_W-1:0]  range_rate
);
  import crp_pkg::*;
  `include "assert_macros.svh"

  // fully pipelined, never backs up
  assign busy = 1'b0;

  logic        accept;
  assign accept = start && !busy;

  // range and dot-product path
  logic        fr_valid;
  logic [63:0] fr_sum;
  dot_t        fr_dot;
  root_t       rt;
  logic        dv_valid;
  logic [31:0] dv_range;
  logic [RATE_W-1:0] dv_rate;

  crp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .out_valid (fr_valid),
    .sum_sq    (fr_sum),
    .dot       (fr_dot)
  );

  crp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .sum_sq   (fr_sum),
    .dot_in   (fr_dot),
    .root     (rt)
  );

  crp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .root      (rt),
    .out_valid (dv_valid),
    .range     (dv_range),
    .rate      (dv_rate)
  );

  // bearing path, payload only; timing matches the range path
  logic signed [BEARING_W-1:0] cd_bearing;
  logic signed [BEARING_W-1:0] bdly [0:BEAR_DELAY-1];

  crp_cordic u_cordic (
    .clk     (clk),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .bearing (cd_bearing)
  );

  always_ff @(posedge clk) begin
    bdly[0] <= cd_bearing;
    for (int i = 1; i < BEAR_DELAY; i++) begin
      bdly[i] <= bdly[i-1];
    end
  end

  // output register; zero position forces bearing to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    range      <= dv_range;
    range_rate <= dv_rate;
    bearing    <= (dv_range == '0) ? '0 : bdly[BEAR_DELAY-1];
  end

  // zero range gives an all-zero measurement
  `ASSERT_IMPL(a_zero_range, clk, rst, done && range == '0,
               bearing == '0 && range_rate == '0)
  // every result traces back to a command transfer
  `ASSERT_IMPL(a_done_src, clk, rst, done, $past(accept, TOTAL_LAT))

endmodule

@@ verif/cartesian_to_polar_radar_top_tb.sv @@
// Testbench for the Cartesian-to-polar radar measurement pipeline.
`timescale 1ns / 100ps

module cartesian_to_polar_radar_top_tb;
  import crp_pkg::*;

  // One track state presented to the block.
  typedef struct {
    logic signed [31:0] px, py, vx, vy;
  } track_t;

  // One polar measurement coming back.
  typedef struct {
    logic [31:0]          rng;
    logic [BEARING_W-1:0] brg;
    logic [RATE_W-1:0]    rate;
  } polar_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
  logic busy, done;
  logic [31:0] range;
  logic signed [BEARING_W-1:0] bearing;
  logic signed [RATE_W-1:0] range_rate;

  cartesian_to_polar_radar_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .done(done), .range(range), .bearing(bearing), .range_rate(range_rate)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  track_t pending_tracks[$];
  polar_t expected_meas[$];
  int     gap_pct = 0;
  bit     stim_done = 1'b0;
  int     n_sent = 0, n_checked = 0, n_mismatch = 0;

  // atan(2^-i) in binary-angle units (full turn = 2^32)
  function automatic logic [31:0] atan_step(int i);
    logic [31:0] tab[32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
    return tab[i];
  endfunction

  // Binary angle of (x, y) via quadrant fold plus vectoring iterations.
  function automatic logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] z;
    longint t, dx, dy;
    z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 32'h40000000;
      end else begin
        t = x; x = -y; y = t; z = 32'hC0000000;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  // Binary angle to radians, Q3.FRAC_BITS, round half up on magnitude.
  function automatic logic [BEARING_W-1:0] angle_radians(logic [31:0] z);
    logic [63:0] m, r;
    m = z[31] ? {32'd0, -z} : {32'd0, z};
    r = (m * 64'd3373259426 + (64'd1 << (ANG_SH - 1))) >> ANG_SH;
    if (z[31]) r = -r;
    return r[BEARING_W-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic polar_t radar_measure(track_t t);
    polar_t o;
    longint px, py, vx, vy;
    logic [63:0] ax, ay, n, s, p1, p2, dmag, q, r;
    bit s1, s2, dneg;
    px = t.px; py = t.py; vx = t.vx; vy = t.vy;
    ax = px < 0 ? -px : px;
    ay = py < 0 ? -py : py;
    n = ax * ax + ay * ay;
    s = int_sqrt(n);
    if (n - s * s > s) s++;
    if (s == 0) begin
      o.rng = '0; o.brg = '0; o.rate = '0;
      return o;
    end
    p1 = ax * (vx < 0 ? -vx : vx);
    s1 = (px < 0) != (vx < 0);
    p2 = ay * (vy < 0 ? -vy : vy);
    s2 = (py < 0) != (vy < 0);
    if (s1 == s2) begin
      dmag = p1 + p2; dneg = s1;
    end else if (p1 >= p2) begin
      dmag = p1 - p2; dneg = s1;
    end else begin
      dmag = p2 - p1; dneg = s2;
    end
    q = dmag / s;
    r = dmag % s;
    if (2 * r >= s) q++;
    if (dneg) begin
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      q = -q;
    end else if (q > 64'hFFFF_FFFF) begin
      q = 64'hFFFF_FFFF;
    end
    o.rng = s[31:0];
    o.brg = angle_radians(vector_angle(px, py));
    o.rate = q[RATE_W-1:0];
    return o;
  endfunction

  // Driver: pops a track state when the sender is not idling this cycle.
  // start stays high across back-to-back transfers (one NBA per edge).
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_meas.push_back(radar_measure('{pos_x, pos_y, vel_x, vel_y}));
        n_sent++;
      end
      if ((!start || !busy) && pending_tracks.size() > 0 &&
          $urandom_range(99) >= gap_pct) begin
        track_t t;
        t = pending_tracks.pop_front();
        start <= 1'b1;
        pos_x <= t.px; pos_y <= t.py; vel_x <= t.vx; vel_y <= t.vy;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results last one cycle and cannot be stalled.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_meas.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: unexpected result range=%h", range);
      end else begin
        polar_t e;
        e = expected_meas.pop_front();
        n_checked++;
        if (e.rng !== range || e.brg !== bearing || e.rate !== range_rate) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"ERROR: result %0d exp rng=%h brg=%h rate=%h",
                      " got rng=%h brg=%h rate=%h"},
                     n_checked, e.rng, e.brg, e.rate, range, bearing, range_rate);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $signed($urandom_range(2047)) - 1024;            // near origin
      2: v = $signed({1'($urandom_range(1)), 31'd0}) + $urandom_range(3); // near extreme
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic add_track(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    pending_tracks.push_back('{a, b, c, d});
  endtask

  initial begin
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    // Directed: origin, axes, extremes, the -pi wrap, saturating rate.
    add_track(0, 0, mx, mn);
    add_track(mx, 0, mx, 0);
    add_track(mn, 0, mn, 0);
    add_track(0, mx, 0, mx);
    add_track(0, mn, 0, mn);
    add_track(mx, mx, mx, mx);
    add_track(mn, mn, mn, mn);
    add_track(mn, mx, mx, mn);
    add_track(mx, mn, mn, mx);
    add_track(mn, 1, 0, 0);
    add_track(mn, -1, 0, 0);
    add_track(-1, 0, 1, 0);
    add_track(-65536, 1, 0, 0);
    add_track(-65536, -1, 0, 0);
    add_track(1, 0, mn, 0);
    add_track(1, 1, mx, mx);
    add_track(1, 1, mn, mn);
    add_track(3, 4, mx, mx);
    add_track(1, 0, 0, 0);
    add_track(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_track(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Three idling phases, 250 random transfers each.
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 38 : (ph == 1) ? 77 : 0;
      for (int k = 0; k < 250; k++)
        add_track(rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
                  rand_coord($urandom_range(3)), rand_coord($urandom_range(3)));
      while (pending_tracks.size() > 0) @(posedge clk);
    end
    @(posedge clk);
    while (expected_meas.size() > 0) @(posedge clk);
    repeat (TOTAL_LAT + 5) @(posedge clk);
    $display("Sent %0d track states over three idling phases;", n_sent);
    $display("%0d results checked, %0d mismatches.", n_checked, n_mismatch);
    if (n_mismatch == 0 && expected_meas.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ cartesian_to_polar_radar_top.f @@
+incdir+hdl
hdl/crp_pkg.sv
hdl/crp_front.sv
hdl/crp_sqrt.sv
hdl/crp_div.sv
hdl/crp_cordic.sv
hdl/cartesian_to_polar_radar_top.sv
verif/cartesian_to_polar_radar_top_tb.sv
